// ===== rtl/core/bq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bq_pkg
// Shared widths, types and register codes for the biquad low-pass filter.
// ----------------------------------------------------------------------------
package bq_pkg;

  localparam int SAMPLE_WIDTH   = 16;
  localparam int COEF_WIDTH     = 21;
  localparam int COEF_FRAC_BITS = 18;
  localparam int NUM_COEFS      = 5;
  localparam int CFG_IDX_W      = $clog2(NUM_COEFS);

  // product and exact accumulator widths
  localparam int PROD_W = SAMPLE_WIDTH + COEF_WIDTH;
  localparam int ACC_W  = SAMPLE_WIDTH + COEF_WIDTH + 3;
  localparam int QUO_W  = ACC_W - COEF_FRAC_BITS;

  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
  typedef logic signed [COEF_WIDTH-1:0]   coef_t;

  // coefficient register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FF0 = CFG_IDX_W'(0),
    REG_FF1 = CFG_IDX_W'(1),
    REG_FF2 = CFG_IDX_W'(2),
    REG_FB1 = CFG_IDX_W'(3),
    REG_FB2 = CFG_IDX_W'(4)
  } reg_idx_t;

  typedef struct packed {
    coef_t ff0;
    coef_t ff1;
    coef_t ff2;
    coef_t fb1;
    coef_t fb2;
  } coef_set_t;

  // two past inputs and two past outputs
  typedef struct packed {
    sample_t x1;
    sample_t x2;
    sample_t y1;
    sample_t y2;
  } hist_t;

  typedef struct packed {
    sample_t sample_out;
    logic    clipped;
  } bq_res_t;

  localparam coef_set_t COEF_RESET = '{
    ff0: COEF_WIDTH'(1207),
    ff1: COEF_WIDTH'(2414),
    ff2: COEF_WIDTH'(1207),
    fb1: COEF_WIDTH'(-471612),
    fb2: COEF_WIDTH'(214299)
  };

  localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

endpackage

// ===== rtl/core/bq_ifs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bq_ifs
// Valid/ready channels of the biquad filter: samples in, results out, config.
// ----------------------------------------------------------------------------

// input sample channel
interface bq_in_if import bq_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

// filtered result channel
interface bq_out_if import bq_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t sample_out;
  logic    clipped;

  modport source (output valid, output sample_out, output clipped, input ready);
  modport sink   (input valid, input sample_out, input clipped, output ready);
endinterface

// coefficient write channel
interface bq_cfg_if import bq_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  coef_t                data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/biquad_lowpass_filter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// biquad_lowpass_filter
// Direct form I biquad with programmable fixed-point coefficients.
// ----------------------------------------------------------------------------
// Usage:
//   in_if   carries one signed sample per request; out_if returns exactly one
//   rounded, saturated sample with a clipped flag per input, in order.
//   cfg_if writes coefficient registers ff0, ff1, ff2, fb1, fb2 (indexes 0..4);
//   any write to a valid index also clears the four history entries, other
//   indexes are ignored. cfg_if is always ready; write only while idle.
// Timing:
//   a sample is captured in an input register, then the five products, sum,
//   rounding and saturation settle combinationally into the output register.
//   Throughput is one sample per cycle while out_if.ready is high; the
//   feedback of y1 returns combinationally into the history register.
// Reset:
//   synchronous, active low; coefficients return to their default low-pass
//   values, history is cleared and both stages are emptied.
// Stall:
//   while out_if.ready is low the result holds, the input register keeps its
//   sample, and in_if.ready drops once both stages are full.
// ----------------------------------------------------------------------------
module biquad_lowpass_filter import bq_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  bq_in_if.sink   in_if,
  bq_out_if.source out_if,
  bq_cfg_if.sink  cfg_if
);

  logic      s1_valid_r;
  sample_t   s1_x_r;
  logic      out_valid_r;
  bq_res_t   out_res_r;
  hist_t     hist_r;
  hist_t     hist_nxt;
  coef_set_t coef_r;
  bq_res_t   mac_res;
  logic      advance;
  logic      in_take;
  logic      cfg_take;

  // handshake
  assign advance      = s1_valid_r & (~out_valid_r | out_if.ready);
  assign in_if.ready  = ~s1_valid_r | advance;
  assign in_take      = in_if.valid & in_if.ready;
  assign cfg_if.ready = 1'b1;
  assign cfg_take     = cfg_if.valid;

  assign out_if.valid      = out_valid_r;
  assign out_if.sample_out = out_res_r.sample_out;
  assign out_if.clipped    = out_res_r.clipped;

  // filter arithmetic
  bq_mac u_mac (
    .x     (s1_x_r),
    .hist  (hist_r),
    .coefs (coef_r),
    .res   (mac_res)
  );

  // history shift when a sample moves into the output register,
  // cleared by a write to a real coefficient register
  always_comb begin
    hist_nxt = hist_r;
    if (advance) begin
      hist_nxt.x2 = hist_r.x1;
      hist_nxt.x1 = s1_x_r;
      hist_nxt.y2 = hist_r.y1;
      hist_nxt.y1 = mac_res.sample_out;
    end
    if (cfg_take && (cfg_if.index inside {REG_FF0, REG_FF1, REG_FF2, REG_FB1, REG_FB2})) begin
      hist_nxt = '0;
    end
  end

  // input stage, output stage, history and coefficients
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      hist_r      <= '0;
      coef_r      <= COEF_RESET;
    end else begin
      if (in_take) begin
        s1_valid_r <= 1'b1;
      end else if (advance) begin
        s1_valid_r <= 1'b0;
      end

      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end

      hist_r <= hist_nxt;

      // coefficient writes
      if (cfg_take) begin
        case (cfg_if.index)
          REG_FF0: begin
            coef_r.ff0 <= cfg_if.data;
          end
          REG_FF1: begin
            coef_r.ff1 <= cfg_if.data;
          end
          REG_FF2: begin
            coef_r.ff2 <= cfg_if.data;
          end
          REG_FB1: begin
            coef_r.fb1 <= cfg_if.data;
          end
          REG_FB2: begin
            coef_r.fb2 <= cfg_if.data;
          end
          default: begin
          end
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_x_r <= in_if.sample_in;
    end
    if (advance) begin
      out_res_r <= mac_res;
    end
  end

endmodule

// ===== rtl/core/bq_mac.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bq_mac
// Five products, exact sum, round to nearest and saturate to sample width.
// ----------------------------------------------------------------------------
module bq_mac import bq_pkg::*; (
  input  sample_t   x,
  input  hist_t     hist,
  input  coef_set_t coefs,
  output bq_res_t   res
);

  localparam logic signed [ACC_W-1:0] ROUND_C = ACC_W'(1) << (COEF_FRAC_BITS - 1);

  logic signed [PROD_W-1:0] p_ff0, p_ff1, p_ff2, p_fb1, p_fb2;
  logic signed [ACC_W-1:0]  acc;
  logic signed [QUO_W-1:0]  quo;
  logic                     in_range;

  // independent products
  assign p_ff0 = PROD_W'(signed'(x))       * PROD_W'(signed'(coefs.ff0));
  assign p_ff1 = PROD_W'(signed'(hist.x1)) * PROD_W'(signed'(coefs.ff1));
  assign p_ff2 = PROD_W'(signed'(hist.x2)) * PROD_W'(signed'(coefs.ff2));
  assign p_fb1 = PROD_W'(signed'(hist.y1)) * PROD_W'(signed'(coefs.fb1));
  assign p_fb2 = PROD_W'(signed'(hist.y2)) * PROD_W'(signed'(coefs.fb2));

  // exact sum plus half an lsb
  assign acc = ACC_W'(p_ff0) + ACC_W'(p_ff1) + ACC_W'(p_ff2)
             - ACC_W'(p_fb1) - ACC_W'(p_fb2) + ROUND_C;

  // floor by dropping the fraction bits
  assign quo = acc[ACC_W-1:COEF_FRAC_BITS];

  // fits when all bits above the sample sign agree with it
  assign in_range = (&quo[QUO_W-1:SAMPLE_WIDTH-1]) | ~(|quo[QUO_W-1:SAMPLE_WIDTH-1]);

  // saturation
  always_comb begin
    if (in_range) begin
      res.sample_out = quo[SAMPLE_WIDTH-1:0];
      res.clipped    = 1'b0;
    end else if (quo[QUO_W-1]) begin
      res.sample_out = SAMPLE_MIN;
      res.clipped    = 1'b1;
    end else begin
      res.sample_out = SAMPLE_MAX;
      res.clipped    = 1'b1;
    end
  end

endmodule

// ===== rtl/core/bq_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bq_checker
// Port-level checks of the biquad filter, bound to the top level.
// ----------------------------------------------------------------------------
module bq_checker import bq_pkg::*; (
  input logic    clk,
  input logic    rst_n,
  input logic    in_valid,
  input logic    in_ready,
  input logic    out_valid,
  input logic    out_ready,
  input sample_t sample_out,
  input logic    clipped
);

  logic [1:0] inflight_r;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_valid & in_ready;
  assign out_acc = out_valid & out_ready;

  // requests accepted but not yet delivered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inflight_r <= 2'd0;
    end else begin
      inflight_r <= inflight_r + 2'(in_acc) - 2'(out_acc);
    end
  end

  // no result without a pending request
  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> inflight_r != 2'd0)
    else $error("result shown with no pending request");

  // at most two requests in the pipeline
  a_depth: assert property (@(posedge clk) disable iff (!rst_n)
    inflight_r == 2'd2 && !out_acc |-> !in_ready)
    else $error("input accepted with both stages full");

  // a clipped result sits at a rail
  a_clip_rail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && clipped |-> sample_out == SAMPLE_MAX || sample_out == SAMPLE_MIN)
    else $error("clipped result not saturated");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(sample_out) && $stable(clipped))
    else $error("stalled result changed");

endmodule

bind biquad_lowpass_filter bq_checker u_bq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_if.valid),
  .in_ready   (in_if.ready),
  .out_valid  (out_if.valid),
  .out_ready  (out_if.ready),
  .sample_out (out_if.sample_out),
  .clipped    (out_if.clipped)
);
